FILE: sv/bcrf_pkg.sv
// Package with shared constants and types of the budget change report filter.
`timescale 1ns / 1ps

package bcrf_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_TIME_WIDTH  = 32;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int OUT_DATA_WIDTH  = 8;

    localparam int THRESHOLD_RESET = 6554;
    localparam int INTERVAL_RESET  = 5;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CHANGE_THRESHOLD = 2'd0,
        CFG_CONN_CAPACITY    = 2'd1,
        CFG_FETCH_CAPACITY   = 2'd2,
        CFG_MIN_INTERVAL     = 2'd3
    } cfg_reg_t;

endpackage

FILE: sv/budget_change_report_filter_unit.sv
// Send-on-delta filter that decides which budget samples are written out.
// A beat is taken into the input registers and moves on into the result registers.
// Throughput: one beat per cycle unless the output stalls; the decision and the state update
// of the confirmed and attempted samples happen together between input and result registers.
// Reset: asynchronous, active low; clears the held-sample flags and loads the register defaults.
// After reset the block accepts beats at once.
`timescale 1ns / 1ps

module budget_change_report_filter_unit
    import bcrf_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int THR_WIDTH     = FRAC_BITS + 1,
    localparam int IN_BITS       = 2 * COUNT_WIDTH + TIME_WIDTH + 1,
    localparam int IN_DATA_WIDTH = ((IN_BITS + 7) / 8) * 8,
    localparam int CW_A          = (THR_WIDTH > COUNT_WIDTH) ? THR_WIDTH : COUNT_WIDTH,
    localparam int CFG_WIDTH     = (CW_A > TIME_WIDTH) ? CW_A : TIME_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Fields from bit 0 up: connection count, fetch count, tick, write success, zero fill.
    input  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata,
    // Fields from bit 0 up: fetch presence flag.
    input  logic                       s_axis_tuser,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: attempt, published, zero fill.
    output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    localparam int PROD_WIDTH = COUNT_WIDTH + FRAC_BITS + 1;

    logic [THR_WIDTH-1:0]   change_threshold_reg;
    logic [COUNT_WIDTH-1:0] conn_capacity_reg;
    logic [COUNT_WIDTH-1:0] fetch_capacity_reg;
    logic [TIME_WIDTH-1:0]  min_interval_reg;

    logic                   in_valid_reg;
    logic [COUNT_WIDTH-1:0] in_conn_reg;
    logic                   in_fetch_on_reg;
    logic [COUNT_WIDTH-1:0] in_fetch_reg;
    logic [TIME_WIDTH-1:0]  in_now_reg;
    logic                   in_ok_reg;

    logic                   confirmed_valid_reg;
    logic [COUNT_WIDTH-1:0] confirmed_conn_reg;
    logic                   confirmed_fetch_on_reg;
    logic [COUNT_WIDTH-1:0] confirmed_fetch_reg;
    logic [TIME_WIDTH-1:0]  confirmed_time_reg;

    logic                   attempted_valid_reg;
    logic [COUNT_WIDTH-1:0] attempted_conn_reg;
    logic                   attempted_fetch_on_reg;
    logic [COUNT_WIDTH-1:0] attempted_fetch_reg;
    logic [TIME_WIDTH-1:0]  attempted_time_reg;
    logic                   attempted_success_reg;

    logic                   out_valid_reg;
    logic                   attempt_reg;
    logic                   published_reg;

    logic                   fire;
    logic                   accept;
    logic                   same_as_attempted;
    logic                   conn_diff;
    logic                   fetch_diff;
    logic                   conn_exceeds;
    logic                   fetch_exceeds;
    logic                   conn_refill;
    logic                   fetch_refill;
    logic [TIME_WIDTH-1:0]  since_confirmed;
    logic [TIME_WIDTH-1:0]  since_attempted;
    logic                   wants_write;
    logic                   go_next;

    function automatic logic exceeds(
        input logic [COUNT_WIDTH-1:0] old_val,
        input logic [COUNT_WIDTH-1:0] cur_val,
        input logic [THR_WIDTH-1:0]   thr
    );
        logic [COUNT_WIDTH-1:0] diff;
        logic [PROD_WIDTH-1:0]  lhs;
        logic [PROD_WIDTH-1:0]  rhs;
        diff = (old_val > cur_val) ? (old_val - cur_val) : (cur_val - old_val);
        lhs  = {1'b0, diff, {FRAC_BITS{1'b0}}};
        rhs  = PROD_WIDTH'(PROD_WIDTH'(thr) * PROD_WIDTH'(old_val));
        return (old_val != cur_val) &&
               ((old_val == '0) || (cur_val == '0) || (lhs >= rhs));
    endfunction

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        same_as_attempted = attempted_valid_reg &&
                            (attempted_conn_reg == in_conn_reg) &&
                            (attempted_fetch_on_reg == in_fetch_on_reg) &&
                            (attempted_fetch_reg == in_fetch_reg);
        conn_diff  = confirmed_conn_reg != in_conn_reg;
        fetch_diff = (confirmed_fetch_on_reg != in_fetch_on_reg) ||
                     (confirmed_fetch_on_reg && (confirmed_fetch_reg != in_fetch_reg));
        conn_exceeds  = exceeds(confirmed_conn_reg, in_conn_reg, change_threshold_reg);
        fetch_exceeds = confirmed_fetch_on_reg &&
                        exceeds(confirmed_fetch_reg, in_fetch_reg, change_threshold_reg);
        conn_refill   = (conn_capacity_reg != '0) && (in_conn_reg == conn_capacity_reg) &&
                        (confirmed_conn_reg != conn_capacity_reg);
        fetch_refill  = confirmed_fetch_on_reg && (fetch_capacity_reg != '0) &&
                        (in_fetch_reg == fetch_capacity_reg) &&
                        (confirmed_fetch_reg != fetch_capacity_reg);
        since_confirmed = in_now_reg - confirmed_time_reg;
        since_attempted = in_now_reg - attempted_time_reg;

        if (!confirmed_valid_reg)
        begin
            wants_write = 1'b1;
        end
        else if (!conn_diff && !fetch_diff)
        begin
            wants_write = 1'b0;
        end
        else
        begin
            wants_write = conn_exceeds || fetch_exceeds || conn_refill || fetch_refill ||
                          (confirmed_fetch_on_reg != in_fetch_on_reg) ||
                          (since_confirmed >= min_interval_reg);
        end

        if (same_as_attempted)
        begin
            go_next = !attempted_success_reg && (since_attempted >= min_interval_reg);
        end
        else
        begin
            go_next = wants_write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_threshold_reg <= THR_WIDTH'(THRESHOLD_RESET);
            conn_capacity_reg    <= '0;
            fetch_capacity_reg   <= '0;
            min_interval_reg     <= TIME_WIDTH'(INTERVAL_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[THR_WIDTH-1:0];
                CFG_CONN_CAPACITY:    conn_capacity_reg    <= cfg_data[COUNT_WIDTH-1:0];
                CFG_FETCH_CAPACITY:   fetch_capacity_reg   <= cfg_data[COUNT_WIDTH-1:0];
                CFG_MIN_INTERVAL:     min_interval_reg     <= cfg_data[TIME_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_conn_reg     <= s_axis_tdata[COUNT_WIDTH-1:0];
            in_fetch_reg    <= s_axis_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
            in_now_reg      <= s_axis_tdata[2*COUNT_WIDTH+TIME_WIDTH-1:2*COUNT_WIDTH];
            in_ok_reg       <= s_axis_tdata[2*COUNT_WIDTH+TIME_WIDTH];
            in_fetch_on_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            confirmed_valid_reg <= 1'b0;
            attempted_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire && go_next)
            begin
                attempted_valid_reg <= 1'b1;
                if (in_ok_reg)
                begin
                    confirmed_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            attempt_reg   <= go_next;
            published_reg <= go_next && in_ok_reg;
            if (go_next)
            begin
                attempted_conn_reg     <= in_conn_reg;
                attempted_fetch_on_reg <= in_fetch_on_reg;
                attempted_fetch_reg    <= in_fetch_reg;
                attempted_time_reg     <= in_now_reg;
                attempted_success_reg  <= in_ok_reg;
                if (in_ok_reg)
                begin
                    confirmed_conn_reg     <= in_conn_reg;
                    confirmed_fetch_on_reg <= in_fetch_on_reg;
                    confirmed_fetch_reg    <= in_fetch_reg;
                    confirmed_time_reg     <= in_now_reg;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_WIDTH-2){1'b0}}, published_reg, attempt_reg};

`ifndef SYNTHESIS
    a_published_needs_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (attempt_reg || !published_reg))
        else $error("published result without an attempt");

    a_confirm_after_success: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && go_next && in_ok_reg) |=> (confirmed_valid_reg && attempted_success_reg))
        else $error("successful write did not confirm the sample");

    a_confirmed_implies_attempted: assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_valid_reg |-> attempted_valid_reg)
        else $error("confirmed sample without an attempted sample");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");
`endif

endmodule
